// ----- hw/rtl/cap_pkg.sv -----
// shared types and constants for the cascaded attitude controller
`timescale 1ns / 1ps
`default_nettype none
package cap_pkg;

  localparam int ANGLE_SUM_LIMIT = 2000000;
  localparam int RATE_SUM_LIMIT  = 2000000;
  localparam int DRIVE_LIMIT     = 500;

  localparam int ACC_W  = 44;
  localparam int SUM_W  = 24;
  localparam int ERR_W  = 18;
  localparam int NUM_REGS = 8;

  localparam logic [2:0] REG_ENABLE  = 3'd0;
  localparam logic [2:0] REG_OUTER_P = 3'd1;
  localparam logic [2:0] REG_OUTER_I = 3'd2;
  localparam logic [2:0] REG_YAW_D   = 3'd3;
  localparam logic [2:0] REG_INNER_P = 3'd4;
  localparam logic [2:0] REG_INNER_I = 3'd5;
  localparam logic [2:0] REG_INNER_D = 3'd6;
  localparam logic [2:0] REG_BASE    = 3'd7;

  // multiply-accumulate unit commands
  typedef struct packed {
    logic              start;    // load accumulator with product (else add)
    logic signed [24:0] a;
    logic [15:0]        b;
  } mac_cmd_t;

endpackage
`default_nettype wire

// ----- hw/rtl/cascaded_attitude_pid.sv -----
// cascaded attitude pid: top level with sequencer and state
// when enabled, a request passes the RUN, FIN and OUT states before its result is valid;
// when disabled it goes straight to OUT; no new request is taken until the result is taken
// (RUN issues 12 products on the single shared multiplier, one per cycle, plus sum, error and
// saturation steps, then the finish and output states, and the result handoff)
// reset: synchronous active low; clears integrators, history, registers (base 1000)
// result register frees the input side once the result is taken
`timescale 1ns / 1ps
`default_nettype none
module cascaded_attitude_pid (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic               in_clear_state,
  input  wire logic signed [15:0] in_pitch_target,
  input  wire logic signed [15:0] in_roll_target,
  input  wire logic signed [15:0] in_yaw_target,
  input  wire logic signed [15:0] in_pitch_angle,
  input  wire logic signed [15:0] in_roll_angle,
  input  wire logic signed [15:0] in_yaw_angle,
  input  wire logic signed [15:0] in_roll_rate,
  input  wire logic signed [15:0] in_pitch_rate,
  input  wire logic        [9:0]  in_throttle,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [10:0]      out_pitch_drive,
  output logic signed [10:0]      out_roll_drive,
  output logic signed [10:0]      out_yaw_drive,
  output logic        [10:0]      out_motor_one,
  output logic        [10:0]      out_motor_two,
  output logic        [10:0]      out_motor_three,
  output logic        [10:0]      out_motor_four,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [15:0]        cfg_data
);
  localparam int AW = cap_pkg::ACC_W;
  localparam int SW = cap_pkg::SUM_W;
  localparam int EW = cap_pkg::ERR_W;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_RUN  = 4'b0010,
    ST_OUT  = 4'b0100,
    ST_FIN  = 4'b1000
  } state_t;

  state_t state_r, state_nxt;
  logic [4:0] step_r;

  logic        enable_r;
  logic [15:0] gain_r [1:6];
  logic [10:0] base_r;

  logic signed [SW-1:0] asum_r [2];
  logic signed [SW-1:0] rsum_r [2];
  logic signed [EW-1:0] last_r [2];
  logic signed [EW-1:0] ylast_r;

  // captured request
  logic signed [16:0] aerr_r [2];
  logic signed [16:0] yerr_r;
  logic signed [15:0] rate_r [2];
  logic               run_r;
  logic [9:0]         thr_r;
  logic signed [EW-1:0] rerr_r;
  logic signed [10:0] drv_r [3];

  cap_pkg::mac_cmd_t cmd;
  logic signed [AW-1:0] acc;
  logic mac_en;

  cap_mac u_mac (.clk(clk), .en(mac_en), .cmd(cmd), .acc(acc));

  assign in_ready  = (state_r == ST_IDLE) && !out_valid;
  assign cfg_ready = 1'b1;

  function automatic logic signed [SW-1:0] sat_sum(input logic signed [SW:0] v,
                                                   input int lim);
    logic signed [SW:0] l;
    l = (SW+1)'(lim);
    if (v > l) return SW'(l);
    if (v < -l) return SW'(-l);
    return SW'(v);
  endfunction

  // floor shift by 8 then drive saturation and truncation toward zero
  function automatic logic signed [10:0] to_drive(input logic signed [AW-1:0] a);
    logic signed [AW-9:0] q;
    logic signed [AW-9:0] lim;
    logic signed [AW-9:0] t;
    q = a[AW-1:8];
    lim = (AW-8)'(cap_pkg::DRIVE_LIMIT * 256);
    if (q > lim) q = lim;
    else if (q < -lim) q = -lim;
    t = q[AW-9] ? -((-q) >>> 8) : (q >>> 8);
    return t[10:0];
  endfunction

  // sequence per axis ax: 0 asum upd, 1 p*aerr, 2 +i*asum, 3 rerr, 4 rsum upd and +ip*rerr,
  // 5 +ii*rsum, 6 +id*(rerr-last), 7 drive; then yaw: 16 p*yerr, 17 +d*(yerr-ylast), 18 drive
  logic ax;
  logic [2:0] sub;
  logic signed [SW:0] sum_tmp;
  logic signed [AW-9:0] outer_q;
  logic signed [AW-9:0] rdiff;

  always_comb begin
    ax  = step_r[3];
    sub = step_r[2:0];
    cmd.start = 1'b0;
    cmd.a = '0;
    cmd.b = '0;
    mac_en = 1'b0;
    sum_tmp = '0;
    outer_q = acc[AW-1:8] - (AW-8)'(rate_r[ax]);
    rdiff = '0;
    if (state_r == ST_RUN && !step_r[4]) begin
      case (sub)
        3'd1: begin cmd.start = 1'b1; cmd.a = 25'(aerr_r[ax]); cmd.b = gain_r[1]; mac_en = 1'b1; end
        3'd2: begin cmd.a = 25'(asum_r[ax]); cmd.b = gain_r[2]; mac_en = 1'b1; end
        3'd4: begin cmd.start = 1'b1; cmd.a = 25'(rerr_r); cmd.b = gain_r[4]; mac_en = 1'b1; end
        3'd5: begin cmd.a = 25'(rsum_r[ax]); cmd.b = gain_r[5]; mac_en = 1'b1; end
        3'd6: begin
          cmd.a = 25'(rerr_r) - 25'(last_r[ax]); cmd.b = gain_r[6]; mac_en = 1'b1;
        end
        default: ;
      endcase
    end else if (state_r == ST_RUN) begin
      case (sub)
        3'd0: begin cmd.start = 1'b1; cmd.a = 25'(yerr_r); cmd.b = gain_r[1]; mac_en = 1'b1; end
        3'd1: begin
          cmd.a = 25'(yerr_r) - 25'(ylast_r); cmd.b = gain_r[3]; mac_en = 1'b1;
        end
        default: ;
      endcase
    end
    rdiff = outer_q;
    if (sub == 3'd0) sum_tmp = (SW+1)'(asum_r[ax]) + (SW+1)'(aerr_r[ax]);
    else sum_tmp = (SW+1)'(rsum_r[ax]) + (SW+1)'(rerr_r);
  end

  logic signed [EW-1:0] rerr_sat;
  always_comb begin
    if (rdiff > (AW-8)'(131071)) rerr_sat = 18'sd131071;
    else if (rdiff < -(AW-8)'(131072)) rerr_sat = -18'sd131072;
    else rerr_sat = rdiff[EW-1:0];
  end

  logic signed [12:0] mbase, mp, mm;
  function automatic logic [10:0] mclamp(input logic signed [12:0] v);
    if (v < 13'sd1000) return 11'd1000;
    if (v > 13'sd2000) return 11'd2000;
    return v[10:0];
  endfunction

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (in_valid && in_ready) state_nxt = enable_r ? ST_RUN : ST_OUT;
      ST_RUN:  if (step_r == 5'd18) state_nxt = ST_FIN;
      ST_FIN:  state_nxt = ST_OUT;
      ST_OUT:  state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      step_r   <= '0;
      out_valid <= 1'b0;
      enable_r <= 1'b0;
      for (int i = 1; i <= 6; i++) gain_r[i] <= '0;
      base_r   <= 11'd1000;
      for (int i = 0; i < 2; i++) begin
        asum_r[i] <= '0; rsum_r[i] <= '0; last_r[i] <= '0;
      end
      ylast_r  <= '0;
    end else begin
      state_r <= state_nxt;
      if (out_valid && out_ready) out_valid <= 1'b0;
      if (cfg_valid) begin
        case (cfg_index)
          cap_pkg::REG_ENABLE:  enable_r <= cfg_data[0];
          cap_pkg::REG_OUTER_P: gain_r[1] <= cfg_data;
          cap_pkg::REG_OUTER_I: gain_r[2] <= cfg_data;
          cap_pkg::REG_YAW_D:   gain_r[3] <= cfg_data;
          cap_pkg::REG_INNER_P: gain_r[4] <= cfg_data;
          cap_pkg::REG_INNER_I: gain_r[5] <= cfg_data;
          cap_pkg::REG_INNER_D: gain_r[6] <= cfg_data;
          cap_pkg::REG_BASE:    base_r <= cfg_data[10:0];
          default: ;
        endcase
      end
      if (state_r == ST_IDLE && in_valid && in_ready) begin
        step_r <= '0;
        if (in_clear_state) begin
          for (int i = 0; i < 2; i++) begin
            asum_r[i] <= '0; rsum_r[i] <= '0; last_r[i] <= '0;
          end
          ylast_r <= '0;
        end
      end
      if (state_r == ST_RUN) begin
        step_r <= step_r + 5'd1;
        if (!step_r[4]) begin
          case (sub)
            3'd0: asum_r[ax] <= run_r ? sat_sum(sum_tmp, cap_pkg::ANGLE_SUM_LIMIT) : '0;
            3'd3: rerr_r <= rerr_sat;
            3'd4: rsum_r[ax] <= run_r ? sat_sum(sum_tmp, cap_pkg::RATE_SUM_LIMIT) : '0;
            3'd7: begin
              drv_r[ax] <= to_drive(acc);
              last_r[ax] <= rerr_r;
            end
            default: ;
          endcase
        end else if (sub == 3'd2) begin
          drv_r[2] <= to_drive(acc);
          ylast_r <= yerr_r;
        end
      end
      if (state_r == ST_OUT) begin
        out_valid <= 1'b1;
      end
    end
  end

  // step 3 of an axis: acc holds outer sum; step 4 loads inner with registered rerr, so
  // rsum update and p product both use rerr_r captured at step 3
  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && in_valid && in_ready) begin
      aerr_r[0] <= 17'(in_pitch_target) - 17'(in_pitch_angle);
      aerr_r[1] <= 17'(in_roll_target) - 17'(in_roll_angle);
      yerr_r    <= 17'(in_yaw_target) - 17'(in_yaw_angle);
      rate_r[0] <= in_pitch_rate;
      rate_r[1] <= in_roll_rate;
      run_r     <= in_throttle >= 10'd100;
      thr_r     <= in_throttle;
    end
  end

  always_comb begin
    mbase = 13'(base_r) + 13'(thr_r);
    mp = mbase + 13'(drv_r[1]);
    mm = mbase - 13'(drv_r[1]);
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_OUT) begin
      if (enable_r) begin
        out_pitch_drive <= drv_r[0];
        out_roll_drive  <= drv_r[1];
        out_yaw_drive   <= drv_r[2];
        out_motor_one   <= mclamp(mp);
        out_motor_two   <= mclamp(mm);
        out_motor_three <= mclamp(mm);
        out_motor_four  <= mclamp(mp);
      end else begin
        out_pitch_drive <= '0;
        out_roll_drive  <= '0;
        out_yaw_drive   <= '0;
        out_motor_one   <= 11'd1000;
        out_motor_two   <= 11'd1000;
        out_motor_three <= 11'd1000;
        out_motor_four  <= 11'd1000;
      end
    end
  end

`ifndef SYNTHESIS
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> !in_ready) else $error("accepted while busy");
  a_sum_lim: assert property (@(posedge clk) disable iff (!rst_n)
    (asum_r[0] <= 24'sd2000000) && (asum_r[0] >= -24'sd2000000)) else $error("sum over limit");
  a_out_after: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(state_r) == ST_OUT) else $error("stray result");
`endif
endmodule
`default_nettype wire

// ----- hw/rtl/cap_mac.sv -----
// shared multiply-accumulate unit: one 25x17 product per cycle while en is high
`timescale 1ns / 1ps
`default_nettype none
module cap_mac (
  input  wire logic                        clk,
  input  wire logic                        en,
  input  wire cap_pkg::mac_cmd_t           cmd,
  output logic signed [cap_pkg::ACC_W-1:0] acc
);
  logic signed [cap_pkg::ACC_W-1:0] acc_r, acc_nxt, prod;

  always_comb begin
    prod = cap_pkg::ACC_W'(cmd.a * $signed({1'b0, cmd.b}));
    acc_nxt = cmd.start ? prod : acc_r + prod;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      acc_r <= acc_nxt;
    end
  end

  assign acc = acc_r;
endmodule
`default_nettype wire
